// ===== design/clr_pkg.sv =====
package clr_pkg;

	localparam int SCREEN_PIXELS = 160;
	localparam int STORE_BYTES   = 6400;
	localparam int ROW_BYTES     = 40;
	localparam int COORD_W       = 12;
	localparam int ADDR_W        = 13;
	localparam int COUNT_W       = 13;
	localparam int SPAN_W        = 12;
	localparam int ERR_W         = 14;
	localparam int PIX_W         = $clog2(SCREEN_PIXELS);
	localparam int IDX_W         =
		$clog2((SCREEN_PIXELS - 1) * ROW_BYTES + (SCREEN_PIXELS - 1) / 4 + 1);

	localparam logic [1:0] PIXEL_MASK  = 2'h3;
	localparam logic [1:0] COLOR_RESET = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_MERGE,
		ST_CAPTURE,
		ST_DONE
	} state_t;

	typedef enum logic {
		CMD_DRAW = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic advance;
	} walk_ctrl_t;

	typedef struct packed {
		logic              visible;
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        lane;
	} pix_t;

	function automatic logic [7:0] merge_pixel(logic [7:0] pixels, logic [1:0] lane,
			logic [1:0] color);
		logic [7:0] mask;
		logic [7:0] value;
		mask  = 8'(PIXEL_MASK) << {lane, 1'b0};
		value = 8'(color & PIXEL_MASK) << {lane, 1'b0};
		return (pixels & ~mask) | value;
	endfunction

endpackage

// ===== design/clr_if.sv =====
interface clr_req_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic signed [clr_pkg::COORD_W-1:0]  start_x;
	logic signed [clr_pkg::COORD_W-1:0]  start_y;
	logic signed [clr_pkg::COORD_W-1:0]  end_x;
	logic signed [clr_pkg::COORD_W-1:0]  end_y;
	logic        [clr_pkg::ADDR_W-1:0]   read_address;

	modport source (
		output valid, command, start_x, start_y, end_x, end_y, read_address,
		input  ready
	);
	modport sink (
		input  valid, command, start_x, start_y, end_x, end_y, read_address,
		output ready
	);
endinterface

interface clr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    read_data;
	logic [clr_pkg::COUNT_W-1:0]   pixels_written;

	modport source (
		output valid, read_data, pixels_written,
		input  ready
	);
	modport sink (
		input  valid, read_data, pixels_written,
		output ready
	);
endinterface

// ===== design/clr_walk.sv =====
module clr_walk (
	input  logic                                clk,
	input  clr_pkg::walk_ctrl_t                 ctrl,
	input  logic signed [clr_pkg::COORD_W-1:0]  start_x,
	input  logic signed [clr_pkg::COORD_W-1:0]  start_y,
	input  logic signed [clr_pkg::COORD_W-1:0]  end_x,
	input  logic signed [clr_pkg::COORD_W-1:0]  end_y,
	output clr_pkg::pix_t                       pix
);

	logic signed [clr_pkg::COORD_W:0]   diff_x;
	logic signed [clr_pkg::COORD_W:0]   diff_y;
	logic        [clr_pkg::SPAN_W-1:0]  adx;
	logic        [clr_pkg::SPAN_W-1:0]  ady;
	logic                               steep;

	logic                               steep_q;
	logic signed [clr_pkg::COORD_W-1:0] ax_q;
	logic signed [clr_pkg::COORD_W-1:0] ay_q;
	logic signed [clr_pkg::COORD_W-1:0] bx_q;
	logic signed [clr_pkg::COORD_W-1:0] by_q;
	logic        [clr_pkg::SPAN_W-1:0]  dx_q;
	logic        [clr_pkg::SPAN_W-1:0]  dy_q;

	logic                               swap;
	logic signed [clr_pkg::COORD_W-1:0] x_q;
	logic signed [clr_pkg::COORD_W-1:0] xend_q;
	logic signed [clr_pkg::COORD_W-1:0] y_q;
	logic                               up_q;
	logic signed [clr_pkg::ERR_W-1:0]   err_q;
	logic signed [clr_pkg::ERR_W-1:0]   wrap_q;

	logic signed [clr_pkg::ERR_W-1:0]   err_sub;
	logic signed [clr_pkg::ERR_W-1:0]   err_wrap;

	logic signed [clr_pkg::COORD_W-1:0] px;
	logic signed [clr_pkg::COORD_W-1:0] py;
	logic                               on_x;
	logic                               on_y;
	logic        [clr_pkg::IDX_W-1:0]   idx;

	always_comb begin
		diff_x = {start_x[clr_pkg::COORD_W-1], start_x} - {end_x[clr_pkg::COORD_W-1], end_x};
		diff_y = {start_y[clr_pkg::COORD_W-1], start_y} - {end_y[clr_pkg::COORD_W-1], end_y};
		adx    = diff_x[clr_pkg::COORD_W] ? clr_pkg::SPAN_W'(-diff_x)
		                                  : clr_pkg::SPAN_W'(diff_x);
		ady    = diff_y[clr_pkg::COORD_W] ? clr_pkg::SPAN_W'(-diff_y)
		                                  : clr_pkg::SPAN_W'(diff_y);
		steep  = adx < ady;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			steep_q <= steep;
			ax_q    <= steep ? start_y : start_x;
			ay_q    <= steep ? start_x : start_y;
			bx_q    <= steep ? end_y : end_x;
			by_q    <= steep ? end_x : end_y;
			dx_q    <= steep ? ady : adx;
			dy_q    <= steep ? adx : ady;
		end
	end

	assign swap     = ax_q > bx_q;
	assign err_sub  = err_q - $signed({2'b00, dy_q});
	assign err_wrap = err_q + wrap_q;

	always_ff @(posedge clk) begin
		if (ctrl.setup) begin
			x_q    <= swap ? bx_q : ax_q;
			xend_q <= swap ? ax_q : bx_q;
			y_q    <= swap ? by_q : ay_q;
			up_q   <= swap ? (by_q < ay_q) : (ay_q < by_q);
			err_q  <= $signed({2'b00, dx_q >> 1});
			wrap_q <= $signed({2'b00, dx_q}) - $signed({2'b00, dy_q});
		end else if (ctrl.advance) begin
			x_q <= x_q + clr_pkg::COORD_W'(1);
			if (err_sub[clr_pkg::ERR_W-1]) begin
				y_q   <= up_q ? y_q + clr_pkg::COORD_W'(1) : y_q - clr_pkg::COORD_W'(1);
				err_q <= err_wrap;
			end else begin
				err_q <= err_sub;
			end
		end
	end

	always_comb begin
		px   = steep_q ? y_q : x_q;
		py   = steep_q ? x_q : y_q;
		on_x = !px[clr_pkg::COORD_W-1] &&
		       ($unsigned(px) < clr_pkg::COORD_W'(clr_pkg::SCREEN_PIXELS));
		on_y = !py[clr_pkg::COORD_W-1] &&
		       ($unsigned(py) < clr_pkg::COORD_W'(clr_pkg::SCREEN_PIXELS));
		idx  = clr_pkg::IDX_W'(py[clr_pkg::PIX_W-1:0]) * clr_pkg::IDX_W'(clr_pkg::ROW_BYTES) +
		       (clr_pkg::IDX_W'(px[clr_pkg::PIX_W-1:0]) >> 2);
		pix.visible = on_x && on_y && (32'(idx) < 32'(clr_pkg::STORE_BYTES));
		pix.last    = x_q == xend_q;
		pix.addr    = clr_pkg::ADDR_W'(idx);
		pix.lane    = px[1:0];
	end

endmodule

// ===== design/clr_frame.sv =====
module clr_frame (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [clr_pkg::ADDR_W-1:0]  rd_addr,
	output logic [7:0]                  rd_data,
	input  logic                        wr_en,
	input  logic [clr_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [7:0]                  wr_data,
	output logic                        clearing
);

	logic [7:0]                 mem [clr_pkg::STORE_BYTES];
	logic                       clearing_q;
	logic [clr_pkg::ADDR_W-1:0] clr_cnt_q;
	logic                       mem_we;
	logic [clr_pkg::ADDR_W-1:0] mem_waddr;
	logic [7:0]                 mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == clr_pkg::ADDR_W'(clr_pkg::STORE_BYTES - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + clr_pkg::ADDR_W'(1);
			end
		end
	end

	always_comb begin
		mem_we    = clearing_q || wr_en;
		mem_waddr = clearing_q ? clr_cnt_q : wr_addr;
		mem_wdata = clearing_q ? 8'h00 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data <= mem[rd_addr];
	end

	assign clearing = clearing_q;

endmodule

// ===== design/clipped_line_rasterizer.sv =====
// channel | dir | handshake          | payload
// req     | in  | req.valid/ready    | command, start_x, start_y, end_x, end_y, read_address
// rsp     | out | rsp.valid/ready    | read_data, pixels_written
// cfg     | in  | cfg_we             | cfg_wdata (draw_color)
//
// Read: taken in IDLE, byte captured in CAPTURE, result posted from DONE. Draw:
// load in IDLE, setup in SETUP, then one cycle per major-axis step off screen; a
// plotted pixel passes WALK then MERGE (read-modify-write of the frame store, read
// in WALK, write in MERGE), then DONE posts the result. After reset the frame
// store is swept to zero, one byte a cycle; req.ready stays low meanwhile. A held
// result does not block the next request; the next result waits in DONE until rsp is free.
module clipped_line_rasterizer (
	input  logic         clk,
	input  logic         arst_n,
	clr_req_if.sink      req,
	clr_rsp_if.source    rsp,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_wdata
);

	clr_pkg::state_t              state_q;
	clr_pkg::state_t              state_d;
	clr_pkg::walk_ctrl_t          ctrl;
	clr_pkg::pix_t                pix;

	logic [1:0]                   color_q;
	logic [clr_pkg::COUNT_W-1:0]  count_q;
	logic [7:0]                   data_q;
	logic                         rd_ok_q;
	logic                         rsp_valid_q;
	logic [7:0]                   rsp_data_q;
	logic [clr_pkg::COUNT_W-1:0]  rsp_count_q;

	logic [clr_pkg::ADDR_W-1:0]   rd_addr;
	logic [7:0]                   rd_data;
	logic                         wr_en;
	logic [7:0]                   wr_data;
	logic                         clearing;
	logic                         count_inc;
	logic                         rsp_load;
	logic                         accept;

	clr_walk u_walk (
		.clk     (clk),
		.ctrl    (ctrl),
		.start_x (req.start_x),
		.start_y (req.start_y),
		.end_x   (req.end_x),
		.end_y   (req.end_y),
		.pix     (pix)
	);

	clr_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (pix.addr),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	assign req.ready = (state_q == clr_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		rd_addr   = pix.addr;
		wr_en     = 1'b0;
		wr_data   = clr_pkg::merge_pixel(rd_data, pix.lane, color_q);
		count_inc = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			clr_pkg::ST_CLEAR: begin
				if (!clearing) begin
					state_d = clr_pkg::ST_IDLE;
				end
			end
			clr_pkg::ST_IDLE: begin
				rd_addr = req.read_address;
				if (req.valid) begin
					if (req.command == clr_pkg::CMD_READ) begin
						state_d = clr_pkg::ST_CAPTURE;
					end else begin
						ctrl.load = 1'b1;
						state_d   = clr_pkg::ST_SETUP;
					end
				end
			end
			clr_pkg::ST_SETUP: begin
				ctrl.setup = 1'b1;
				state_d    = clr_pkg::ST_WALK;
			end
			clr_pkg::ST_WALK: begin
				if (pix.visible) begin
					state_d = clr_pkg::ST_MERGE;
				end else begin
					ctrl.advance = 1'b1;
					if (pix.last) begin
						state_d = clr_pkg::ST_DONE;
					end
				end
			end
			clr_pkg::ST_MERGE: begin
				wr_en        = 1'b1;
				count_inc    = 1'b1;
				ctrl.advance = 1'b1;
				state_d      = pix.last ? clr_pkg::ST_DONE : clr_pkg::ST_WALK;
			end
			clr_pkg::ST_CAPTURE: begin
				state_d = clr_pkg::ST_DONE;
			end
			clr_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = clr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clr_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= clr_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= '0;
			data_q  <= '0;
			rd_ok_q <= req.read_address < clr_pkg::ADDR_W'(clr_pkg::STORE_BYTES);
		end else begin
			if (count_inc) begin
				count_q <= count_q + clr_pkg::COUNT_W'(1);
			end
			if (state_q == clr_pkg::ST_CAPTURE) begin
				data_q <= rd_ok_q ? rd_data : 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q  <= data_q;
			rsp_count_q <= count_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = rsp_data_q;
	assign rsp.pixels_written = rsp_count_q;

`ifndef SYNTH
	a_merge_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clr_pkg::ST_MERGE) |-> pix.visible)
		else $error("frame write on a pixel that is off screen");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == clr_pkg::ST_SETUP || state_q == clr_pkg::ST_CAPTURE))
		else $error("accepted request did not start work");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == clr_pkg::ST_DONE))
		else $error("result posted outside the done state");

	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (state_q == clr_pkg::ST_CLEAR))
		else $error("sequencer left clear before the sweep finished");
`endif

endmodule
